// ===== src/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants for the string to unsigned parser
// Widths, phase and status codes, and the classified item passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int BASE_WIDTH  = 6;
    localparam int CHAR_WIDTH  = 8;
    localparam int PROD_WIDTH  = VALUE_WIDTH + BASE_WIDTH;

    // both queues; pointer wrap relies on a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = BASE_WIDTH'(0);
    localparam logic [BASE_WIDTH-1:0] BASE_OCT   = BASE_WIDTH'(8);
    localparam logic [BASE_WIDTH-1:0] BASE_DEC   = BASE_WIDTH'(10);
    localparam logic [BASE_WIDTH-1:0] BASE_HEX   = BASE_WIDTH'(16);
    localparam logic [BASE_WIDTH-1:0] BASE_MAX   = BASE_WIDTH'(36);
    localparam logic [BASE_WIDTH-1:0] DIGIT_NONE = BASE_WIDTH'(36);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_ZX,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_DIGITS,
        ST_OVERFLOW,
        ST_BAD_BASE
    } status_t;

    typedef struct packed {
        logic                  start;
        logic                  base_bad;
        logic [BASE_WIDTH-1:0] base;
        logic                  blank;
        logic                  plus;
        logic                  minus;
        logic                  zero_char;
        logic                  x_char;
        logic [BASE_WIDTH-1:0] digit;
    } stp_item_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_WIDTH-1:0] count;
        status_t                status;
    } stp_result_t;

endpackage

// ===== src/stp_front.sv =====
// ----------------------------------------------------------------------------
// stp_front: character classifier and item queue
// Decodes each accepted character, checks the base on a start item and
// queues the classified item for the back end.
// ----------------------------------------------------------------------------
module stp_front
    import stp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CHAR_WIDTH-1:0] char_in,
    input  logic                  start_req,
    input  logic [BASE_WIDTH-1:0] number_base,
    output stp_item_t             item,
    output logic                  item_valid,
    input  logic                  item_take
);

    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] LETTER_OFS = 8'd10;

    stp_item_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    stp_item_t             cls;
    logic [CHAR_WIDTH-1:0] digit_wide;
    logic                  wr_en;
    logic                  rd_en;

    always_comb
    begin
        if (char_in >= CH_0 && char_in <= CH_9)
        begin
            digit_wide = char_in - CH_0;
        end
        else if (char_in >= CH_LA && char_in <= CH_LZ)
        begin
            digit_wide = char_in - CH_LA + LETTER_OFS;
        end
        else if (char_in >= CH_UA && char_in <= CH_UZ)
        begin
            digit_wide = char_in - CH_UA + LETTER_OFS;
        end
        else
        begin
            digit_wide = CHAR_WIDTH'(DIGIT_NONE);
        end
    end

    always_comb
    begin
        cls.start     = start_req;
        cls.base      = number_base;
        cls.base_bad  = (number_base == BASE_WIDTH'(1)) || (number_base > BASE_MAX);
        // tab, newline, vertical tab, form feed, carriage return are contiguous
        cls.blank     = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
        cls.plus      = (char_in == CH_PLUS);
        cls.minus     = (char_in == CH_MINUS);
        cls.zero_char = (char_in == CH_0);
        cls.x_char    = (char_in == CH_LX) || (char_in == CH_UX);
        cls.digit     = digit_wide[BASE_WIDTH-1:0];
    end

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== src/stp_back.sv =====
// ----------------------------------------------------------------------------
// stp_back: parse sequencer and result queue
// Runs the per-string phase machine, accumulates digits with overflow
// detection and queues one result per finished string.
// ----------------------------------------------------------------------------
module stp_back
    import stp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  stp_item_t              item,
    input  logic                   item_valid,
    output logic                   item_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [COUNT_WIDTH-1:0] consumed_count,
    output logic [1:0]             status
);

    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [BASE_WIDTH-1:0]  base_reg, base_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;

    phase_t                 ph_eff;
    logic                   neg_eff;
    logic [BASE_WIDTH-1:0]  base_eff;
    logic [VALUE_WIDTH-1:0] acc_eff;
    logic                   ovf_eff;
    logic [COUNT_WIDTH-1:0] pos_eff;

    logic [BASE_WIDTH-1:0]  td_base;
    logic [PROD_WIDTH-1:0]  prod;
    logic                   prod_ovf;
    logic                   digit_ok;
    logic [COUNT_WIDTH-1:0] pos_inc;
    logic [COUNT_WIDTH-1:0] pos_dec;
    logic                   do_digit;
    logic                   zero_prefix;

    logic                   res_wr;
    stp_result_t            res;

    stp_result_t            r_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr_reg;
    logic [QPTR_W-1:0]      r_rd_ptr_reg;
    logic [QCNT_W-1:0]      r_cnt_reg, r_cnt_next;
    logic                   fire;
    logic                   r_push;
    logic                   r_pop;
    stp_result_t            r_head;

    assign fire      = item_valid && (r_cnt_reg != QCNT_W'(QDEPTH));
    assign item_take = fire;

    // a start item begins from cleared state
    always_comb
    begin
        if (item.start)
        begin
            ph_eff   = PH_LEAD;
            neg_eff  = 1'b0;
            base_eff = item.base;
            acc_eff  = '0;
            ovf_eff  = 1'b0;
            pos_eff  = '0;
        end
        else
        begin
            ph_eff   = phase_reg;
            neg_eff  = neg_reg;
            base_eff = base_reg;
            acc_eff  = acc_reg;
            ovf_eff  = ovf_reg;
            pos_eff  = pos_reg;
        end
    end

    always_comb
    begin
        if (base_eff == BASE_AUTO)
        begin
            td_base = (ph_eff == PH_ZERO) ? BASE_OCT : BASE_DEC;
        end
        else
        begin
            td_base = base_eff;
        end
    end

    // widened acc * base + digit, anything above the value width is overflow
    assign prod     = PROD_WIDTH'(acc_eff) * PROD_WIDTH'(td_base) + PROD_WIDTH'(item.digit);
    assign prod_ovf = |prod[PROD_WIDTH-1:VALUE_WIDTH];
    assign digit_ok = (item.digit < td_base);
    assign pos_inc  = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
    assign pos_dec  = (pos_eff == '1) ? pos_eff : pos_eff - 1'b1;
    assign zero_prefix = item.zero_char && (base_eff == BASE_AUTO || base_eff == BASE_HEX);

    always_comb
    begin
        phase_next = ph_eff;
        neg_next   = neg_eff;
        base_next  = base_eff;
        acc_next   = acc_eff;
        ovf_next   = ovf_eff;
        pos_next   = pos_eff;
        do_digit   = 1'b0;
        res_wr     = 1'b0;
        res.value  = '0;
        res.count  = '0;
        res.status = ST_OK;

        if (item.start && item.base_bad)
        begin
            res_wr     = 1'b1;
            res.status = ST_BAD_BASE;
            base_next  = BASE_AUTO;
            phase_next = PH_IDLE;
        end
        else
        begin
            case (ph_eff)
                PH_LEAD:
                begin
                    if (item.blank)
                    begin
                        pos_next = pos_inc;
                    end
                    else if (item.plus || item.minus)
                    begin
                        neg_next   = item.minus;
                        pos_next   = pos_inc;
                        phase_next = PH_SIGNED;
                    end
                    else if (zero_prefix)
                    begin
                        pos_next   = pos_inc;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    if (zero_prefix)
                    begin
                        pos_next   = pos_inc;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (item.x_char)
                    begin
                        pos_next   = pos_inc;
                        phase_next = PH_ZX;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                PH_ZX:
                begin
                    if (item.digit < BASE_HEX)
                    begin
                        base_next  = BASE_HEX;
                        acc_next   = VALUE_WIDTH'(item.digit);
                        pos_next   = pos_inc;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        // "0x" without a hex digit: only the zero counts
                        res_wr     = 1'b1;
                        res.count  = pos_dec;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_digit)
            begin
                base_next = td_base;
                if (!digit_ok)
                begin
                    res_wr     = 1'b1;
                    phase_next = PH_IDLE;
                    if (ph_eff != PH_DIGITS && ph_eff != PH_ZERO)
                    begin
                        res.status = ST_NO_DIGITS;
                    end
                    else if (ovf_eff)
                    begin
                        res.value  = '1;
                        res.count  = pos_eff;
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        res.value = neg_eff ? -acc_eff : acc_eff;
                        res.count = pos_eff;
                    end
                end
                else
                begin
                    if (!ovf_eff)
                    begin
                        if (prod_ovf)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = prod[VALUE_WIDTH-1:0];
                        end
                    end
                    pos_next   = pos_inc;
                    phase_next = PH_DIGITS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
        end
    end

    // result queue
    assign r_push = fire && res_wr;
    assign empty  = (r_cnt_reg == '0);
    assign r_pop  = pop && !empty;
    assign r_head = r_mem_reg[r_rd_ptr_reg];

    assign value          = r_head.value;
    assign consumed_count = r_head.count;
    assign status         = r_head.status;

    always_comb
    begin
        r_cnt_next = r_cnt_reg;
        if (r_push && !r_pop)
        begin
            r_cnt_next = r_cnt_reg + 1'b1;
        end
        else if (r_pop && !r_push)
        begin
            r_cnt_next = r_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_wr_ptr_reg <= '0;
            r_rd_ptr_reg <= '0;
            r_cnt_reg    <= '0;
        end
        else
        begin
            if (r_push)
            begin
                r_wr_ptr_reg <= r_wr_ptr_reg + 1'b1;
            end
            if (r_pop)
            begin
                r_rd_ptr_reg <= r_rd_ptr_reg + 1'b1;
            end
            r_cnt_reg <= r_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_push)
        begin
            r_mem_reg[r_wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== src/string_to_unsigned_parser.sv =====
// ----------------------------------------------------------------------------
// string_to_unsigned_parser: ascii string to unsigned integer
// Streams one character per item and gives one result per parsed string.
// ----------------------------------------------------------------------------
// usage:
//   input queue: an item (char_in, start_req) is taken when push is high and
//   full is low. start_req marks the first character of a string; leading
//   blanks, a sign and a base prefix are handled, and the first non-digit
//   closes the string.
//   result queue: while empty is low the oldest result (value,
//   consumed_count, status) is shown; pop takes it.
//   number_base is written with cfg_write; it is sampled at each start item.
//   throughput: one character per cycle while the result queue has room,
//   using a single multiply-add for the digit accumulator in the back end.
//   path: the closing character is registered in the front queue; the back
//   end takes it from there when the result queue has room and registers
//   the result in the result queue, where it is then shown.
//   reset: both queues are emptied, no string is open, number_base is 0.
//   when pop is held low the result queue (two items) fills, then the
//   front queue (two items) fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser
    import stp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [CHAR_WIDTH-1:0]  char_in,
    input  logic                   start_req,
    output logic                   empty,
    input  logic                   pop,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [COUNT_WIDTH-1:0] consumed_count,
    output logic [1:0]             status,
    input  logic                   cfg_write,
    input  logic [BASE_WIDTH-1:0]  number_base
);

    logic [BASE_WIDTH-1:0] base_cfg_reg;
    stp_item_t             item;
    logic                  item_valid;
    logic                  item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_cfg_reg <= number_base;
        end
    end

    stp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .start_req   (start_req),
        .number_base (base_cfg_reg),
        .item        (item),
        .item_valid  (item_valid),
        .item_take   (item_take)
    );

    stp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .consumed_count (consumed_count),
        .status         (status)
    );

endmodule

// ===== src/stp_checker.sv =====
// ----------------------------------------------------------------------------
// stp_checker: port-level checks for the string to unsigned parser
// Watches the result queue and reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module stp_checker
    import stp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   full,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [COUNT_WIDTH-1:0] consumed_count,
    input  logic [1:0]             status
);

    // queues are empty once reset has been seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not empty during reset");

    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == ST_BAD_BASE |-> value == '0 && consumed_count == '0)
        else $error("invalid base item carries data");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == ST_NO_DIGITS |-> value == '0 && consumed_count == '0)
        else $error("no-digit item carries data");

    a_overflow_ones: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == ST_OVERFLOW |-> value == '1 && consumed_count != '0)
        else $error("overflow item not saturated");

    // a waiting item holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(value) && $stable(consumed_count)
            && $stable(status))
        else $error("result changed while stalled");

endmodule

bind string_to_unsigned_parser stp_checker u_stp_checker (.*);
